// ===== hdl/cfi2_pkg.sv =====
`default_nettype none

package cfi2_pkg;

    // Fixed field widths and arithmetic constants
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int COEF_IDX_W = 7;
    localparam int COEF_SLOTS = 128;
    localparam int Q_SHIFT    = 15;

    // Request codes on req_type
    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic coef_wr;      // write coefficient from the input word
        logic take_sample;  // latch the incoming sample
        logic clear;        // clear accumulators, rewind read pointers
        logic phase;        // coefficient phase used at clear
        logic issue;        // issue one tap read into the MAC pipeline
        logic load_out;     // load the output register from the accumulators
        logic last;         // last_of_pair flag for the loaded result
        logic push;         // write the latched sample into the history
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;    // MAC pipeline still holds taps
        logic out_free;     // output register can take a result this cycle
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/cfi2_ctrl.sv =====
`default_nettype none

module cfi2_ctrl
    import cfi2_pkg::*;
#(
    parameter int TAP_COUNT = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_type,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam int HIST_LEN = TAP_COUNT / 2;
    localparam int HW       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;

    ctrl_state_t     state_reg, state_next;
    logic            phase_reg, phase_next;
    logic [HW-1:0]   tap_reg, tap_next;

    // Hold state, phase and tap count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b1;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            tap_reg   <= tap_next;
        end
    end

    // Next state: odd phase first, then even phase, then back to idle
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        tap_next   = tap_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (req_type == REQ_SAMPLE))
                begin
                    state_next = ST_RUN;
                    phase_next = 1'b1;
                    tap_next   = '0;
                end
            end
            ST_RUN:
            begin
                tap_next = tap_reg + 1'b1;
                if (tap_reg == HW'(HIST_LEN - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (phase_reg)
                    begin
                        state_next = ST_RUN;
                        phase_next = 1'b0;
                        tap_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: commands for the datapath
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_SAMPLE)
                    begin
                        cmd.take_sample = 1'b1;
                        cmd.clear       = 1'b1;
                        cmd.phase       = 1'b1;
                    end
                    else
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.last     = !phase_reg;
                    if (phase_reg)
                    begin
                        cmd.clear = 1'b1;
                        cmd.phase = 1'b0;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Idle is reached again only after the sample enters the history
    a_ready_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(cmd.push))
        else $error("input reopened without history push");

    // Each pair ends with the even-phase result flagged last
    a_push_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (cmd.load_out && cmd.last))
        else $error("history push without final result");

endmodule

`default_nettype wire

// ===== hdl/cfi2_datapath.sv =====
`default_nettype none

module cfi2_datapath
    import cfi2_pkg::*;
#(
    parameter int TAP_COUNT = 128
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ctrl_cmd_t                   cmd,
    output dp_status_t                       status,
    input  wire logic [COEF_IDX_W-1:0]       coef_index,
    input  wire logic signed [SAMPLE_W-1:0]  coef_value,
    input  wire logic signed [SAMPLE_W-1:0]  sample_re,
    input  wire logic signed [SAMPLE_W-1:0]  sample_im,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]       out_re,
    output logic signed [SAMPLE_W-1:0]       out_im,
    output logic                             last_of_pair
);

    localparam int HIST_LEN   = TAP_COUNT / 2;
    localparam int HW         = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int COEF_DEPTH = (TAP_COUNT < COEF_SLOTS) ? TAP_COUNT : COEF_SLOTS;
    localparam int CW         = $clog2(COEF_DEPTH);
    localparam int CIX        = $clog2(TAP_COUNT);

    // Storage
    logic [SAMPLE_W-1:0]   coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0] coef_vld_reg;
    logic [2*SAMPLE_W-1:0] hist_mem [HIST_LEN];
    logic [HIST_LEN-1:0]   hist_vld_reg;
    logic [HW-1:0]         head_reg;
    logic [2*SAMPLE_W-1:0] sample_reg;

    // Read pointers
    logic [HW-1:0]         rd_ptr_reg;
    logic [CIX-1:0]        coef_ptr_reg;
    logic                  coef_in_range;
    logic                  coef_wr_ok;

    // Pipeline
    logic                  s1_vld_reg;
    logic                  s1_coef_ok_reg;
    logic                  s1_hist_ok_reg;
    logic [SAMPLE_W-1:0]   coef_q_reg;
    logic [2*SAMPLE_W-1:0] hist_q_reg;
    logic signed [SAMPLE_W-1:0] s1_coef, s1_re, s1_im;
    logic                  s2_vld_reg;
    logic signed [ACC_W-1:0] prod_re_reg, prod_im_reg;
    logic [ACC_W-1:0]      acc_re_reg, acc_im_reg;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]   out_re_reg, out_im_reg;
    logic                  last_reg;

    assign coef_in_range = {1'b0, coef_ptr_reg} < (CIX + 1)'(COEF_DEPTH);
    assign coef_wr_ok    = cmd.coef_wr && ({1'b0, coef_index} < (COEF_IDX_W + 1)'(COEF_DEPTH));

    // Write coefficients and read one tap per issue
    always_ff @(posedge clk)
    begin
        if (coef_wr_ok)
        begin
            coef_mem[coef_index[CW-1:0]] <= coef_value;
        end
        coef_q_reg <= coef_mem[coef_ptr_reg[CW-1:0]];
    end

    // Write the history and read one sample per issue
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            hist_mem[head_reg] <= sample_reg;
        end
        hist_q_reg <= hist_mem[rd_ptr_reg];
    end

    // Track written entries so unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
            head_reg     <= '0;
        end
        else
        begin
            if (coef_wr_ok)
            begin
                coef_vld_reg[coef_index[CW-1:0]] <= 1'b1;
            end
            if (cmd.push)
            begin
                hist_vld_reg[head_reg] <= 1'b1;
                if (head_reg == HW'(HIST_LEN - 1))
                begin
                    head_reg <= '0;
                end
                else
                begin
                    head_reg <= head_reg + 1'b1;
                end
            end
        end
    end

    // Latch the incoming sample, im in the upper half
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
        begin
            sample_reg <= {sample_im, sample_re};
        end
    end

    // Rewind at clear, advance per issue; samples oldest first
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            rd_ptr_reg   <= head_reg;
            coef_ptr_reg <= CIX'(cmd.phase);
        end
        else if (cmd.issue)
        begin
            coef_ptr_reg <= coef_ptr_reg + CIX'(2);
            if (rd_ptr_reg == HW'(HIST_LEN - 1))
            begin
                rd_ptr_reg <= '0;
            end
            else
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Stage 1 and stage 2 valid qualifiers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_coef_ok_reg <= coef_in_range && coef_vld_reg[coef_ptr_reg[CW-1:0]];
        s1_hist_ok_reg <= hist_vld_reg[rd_ptr_reg];
    end

    // Mask entries never written, and coefficients out of range
    assign s1_coef = s1_coef_ok_reg ? signed'(coef_q_reg) : '0;
    assign s1_re   = s1_hist_ok_reg ? signed'(hist_q_reg[SAMPLE_W-1:0]) : '0;
    assign s1_im   = s1_hist_ok_reg ? signed'(hist_q_reg[2*SAMPLE_W-1:SAMPLE_W]) : '0;

    // Stage 2: one complex-by-real product
    always_ff @(posedge clk)
    begin
        prod_re_reg <= ACC_W'(s1_coef) * ACC_W'(s1_re);
        prod_im_reg <= ACC_W'(s1_coef) * ACC_W'(s1_im);
    end

    // Stage 3: wrapping accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_re_reg <= acc_re_reg + prod_re_reg;
            acc_im_reg <= acc_im_reg + prod_im_reg;
        end
    end

    // Output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_re_reg <= acc_re_reg[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
            out_im_reg <= acc_im_reg[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
            last_reg   <= cmd.last;
        end
    end

    assign status.pipe_busy = s1_vld_reg || s2_vld_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_re       = signed'(out_re_reg);
    assign out_im       = signed'(out_im_reg);
    assign last_of_pair = last_reg;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

    // Accumulators clear only with the MAC pipeline empty
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !(s1_vld_reg || s2_vld_reg))
        else $error("accumulator cleared with taps in flight");

    // A result is taken only after the last tap has been summed
    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!s1_vld_reg && !s2_vld_reg && !cmd.issue))
        else $error("result loaded before pipeline drained");

endmodule

`default_nettype wire

// ===== hdl/complex_fir_interpolator_x2_unit.sv =====
// Order: a sample word gives its odd-phase result first and then its even-phase result;
//   the history holds H = TAP_COUNT/2 samples (64 by default).
// Flow: a new word is accepted only after both results of the last sample word are loaded,
//   a wait set by the single complex MAC that walks the history one tap per cycle.
// Reset: rst_n is asynchronous, active low; valid bits clear at once so both stores
//   read as zero, with no clearing pass.
`default_nettype none

module complex_fir_interpolator_x2_unit
    import cfi2_pkg::*;
#(
    parameter int TAP_COUNT = 128
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        req_type,
    input  wire logic [COEF_IDX_W-1:0]       coef_index,
    input  wire logic signed [SAMPLE_W-1:0]  coef_value,
    input  wire logic signed [SAMPLE_W-1:0]  sample_re,
    input  wire logic signed [SAMPLE_W-1:0]  sample_im,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]       out_re,
    output logic signed [SAMPLE_W-1:0]       out_im,
    output logic                             last_of_pair
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequence the two phases
    cfi2_ctrl #(
        .TAP_COUNT (TAP_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores, MAC pipeline and output register
    cfi2_datapath #(
        .TAP_COUNT (TAP_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_re       (out_re),
        .out_im       (out_im),
        .last_of_pair (last_of_pair)
    );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
    import cfi2_pkg::*;

    localparam int HIST_DEPTH = COEF_SLOTS / 2;
    localparam int WORD_COUNT = 1450;
    localparam int LONG_HOLD  = 2000;
    localparam int HOLD_AT    = 400;
    localparam int PAUSE_AT   = 700;
    localparam int DIR_ROWS   = 20;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       last;
    } out_word_t;

    typedef struct packed {
        logic                       rt;
        logic [COEF_IDX_W-1:0]      idx;
        logic signed [SAMPLE_W-1:0] cval;
        logic signed [SAMPLE_W-1:0] s_re;
        logic signed [SAMPLE_W-1:0] s_im;
        logic                       typed;
        out_word_t                  odd_w;
        out_word_t                  even_w;
    } tab_row_t;

    localparam out_word_t NONE      = '0;
    localparam out_word_t ZERO_ODD  = '{16'sh0000, 16'sh0000, 1'b0};
    localparam out_word_t ZERO_EVEN = '{16'sh0000, 16'sh0000, 1'b1};

    // Directed words; typed rows carry results that follow directly from a near-empty filter
    tab_row_t dir_tab [0:DIR_ROWS-1] = '{
        // first push after reset: all taps zero
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b1, ZERO_ODD, ZERO_EVEN},
        '{REQ_COEF, 7'd127, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_COEF, 7'd0, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_COEF, 7'd1, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        // newest sample meets tap 127 on the odd phase only
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b1,
          '{16'sh8001, 16'sh7FFE, 1'b0}, ZERO_EVEN},
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh7FFE, 16'sh8001, 1'b0}, ZERO_EVEN},
        '{REQ_COEF, 7'd126, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh0001, 16'shFFFF, 1'b0, NONE, NONE},
        // most negative taps and samples: accumulator wraps
        '{REQ_COEF, 7'd127, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_COEF, 7'd125, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_COEF, 7'd123, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh8000, 16'sh8000, 1'b0, NONE, NONE},
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh8000, 16'sh8000, 1'b0, NONE, NONE},
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh8000, 16'sh8000, 1'b0, NONE, NONE},
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_COEF, 7'd64, 16'sh0001, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_COEF, 7'd63, 16'shFFFF, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_COEF, 7'd0, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0, NONE, NONE},
        '{REQ_SAMPLE, 7'd0, 16'sh0000, 16'sh3039, 16'shCFC7, 1'b0, NONE, NONE}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       req_type = REQ_COEF;
    logic [COEF_IDX_W-1:0]      coef_index = '0;
    logic signed [SAMPLE_W-1:0] coef_value = '0;
    logic signed [SAMPLE_W-1:0] sample_re = '0;
    logic signed [SAMPLE_W-1:0] sample_im = '0;
    logic                       out_ready = 1'b0;
    wire logic                  in_ready;
    wire logic                  out_valid;
    wire logic signed [SAMPLE_W-1:0] out_re;
    wire logic signed [SAMPLE_W-1:0] out_im;
    wire logic                  last_of_pair;

    // Filter state mirrored by the testbench
    logic signed [SAMPLE_W-1:0] taps [COEF_SLOTS];
    logic [ACC_W-1:0]           history [HIST_DEPTH];
    out_word_t                  pending_outputs [$];

    int n_words   = 0;
    int n_coefs   = 0;
    int n_samples = 0;
    int n_results = 0;
    int n_errors  = 0;

    complex_fir_interpolator_x2_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_re       (out_re),
        .out_im       (out_im),
        .last_of_pair (last_of_pair)
    );

    always #5 clk = ~clk;

    // Sum one polyphase branch over the history, oldest sample first
    function automatic out_word_t phase_output(input int phase, input logic last);
        logic signed [ACC_W-1:0] acc_re;
        logic signed [ACC_W-1:0] acc_im;
        out_word_t               w;
        int                      j;
        acc_re = '0;
        acc_im = '0;
        for (j = 0; j < HIST_DEPTH; j++)
        begin
            acc_re += $signed(history[j][15:0]) * taps[2*j+phase];
            acc_im += $signed(history[j][31:16]) * taps[2*j+phase];
        end
        w.re   = acc_re[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
        w.im   = acc_im[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
        w.last = last;
        return w;
    endfunction

    // Update the mirrored state for one accepted word and queue its results
    task automatic apply_word(input tab_row_t r);
        out_word_t odd_w;
        out_word_t even_w;
        int        j;
        if (r.rt == REQ_COEF)
        begin
            taps[r.idx] = r.cval;
            n_coefs++;
        end
        else
        begin
            odd_w  = phase_output(1, 1'b0);
            even_w = phase_output(0, 1'b1);
            if (r.typed)
            begin
                odd_w  = r.odd_w;
                even_w = r.even_w;
            end
            pending_outputs.push_back(odd_w);
            pending_outputs.push_back(even_w);
            for (j = 0; j < HIST_DEPTH - 1; j++)
                history[j] = history[j+1];
            history[HIST_DEPTH-1] = {r.s_im, r.s_re};
            n_samples++;
        end
    endtask

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input tab_row_t r);
        int gap;
        gap = ((n_words / 100) % 3 == 2) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= r.rt;
        coef_index <= r.idx;
        coef_value <= r.cval;
        sample_re  <= r.s_re;
        sample_im  <= r.s_im;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        apply_word(r);
        n_words++;
    endtask

    // Random 16-bit value, biased toward the extremes
    function automatic logic [SAMPLE_W-1:0] pick16();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic tab_row_t random_word();
        tab_row_t r;
        r      = '0;
        r.rt   = ($urandom_range(0, 3) == 0) ? REQ_COEF : REQ_SAMPLE;
        r.idx  = COEF_IDX_W'($urandom_range(0, COEF_SLOTS - 1));
        r.cval = pick16();
        r.s_re = pick16();
        r.s_im = pick16();
        return r;
    endfunction

    // Compare one output word against the oldest expectation
    task automatic check_output();
        out_word_t exp_w;
        if (pending_outputs.size() == 0)
        begin
            $error("unexpected output word: out_re=%0d out_im=%0d last_of_pair=%0b",
                   out_re, out_im, last_of_pair);
            n_errors++;
        end
        else
        begin
            exp_w = pending_outputs.pop_front();
            if (out_re !== exp_w.re)
            begin
                $error("out_re: expected %0d, got %0d", exp_w.re, out_re);
                n_errors++;
            end
            if (out_im !== exp_w.im)
            begin
                $error("out_im: expected %0d, got %0d", exp_w.im, out_im);
                n_errors++;
            end
            if (last_of_pair !== exp_w.last)
            begin
                $error("last_of_pair: expected %0b, got %0b", exp_w.last, last_of_pair);
                n_errors++;
            end
        end
        n_results++;
    endtask

    // Output side: random stalls, quiet stretches, and one long hold
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (n_results == HOLD_AT)
                gap = LONG_HOLD;
            else
                gap = ((n_results / 150) % 3 == 1) ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            check_output();
        end
    end

    // Input side: reset, directed words, random words with one pause, then drain
    initial
    begin
        int i;
        for (i = 0; i < COEF_SLOTS; i++)
            taps[i] = '0;
        for (i = 0; i < HIST_DEPTH; i++)
            history[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
            send_word(dir_tab[i]);

        for (i = DIR_ROWS; i < WORD_COUNT; i++)
        begin
            // hold off input until every queued result is out
            if (i == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending_outputs.size() != 0);
            end
            send_word(random_word());
        end

        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (2 * HIST_DEPTH + 16) @(posedge clk);

        $display("Covered %0d words: %0d coefficient writes, %0d samples, %0d results checked",
                 n_words, n_coefs, n_samples, n_results);
        $display("Included a %0d-cycle output hold and one full input pause", LONG_HOLD);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/cfi2_pkg.sv
hdl/cfi2_ctrl.sv
hdl/cfi2_datapath.sv
hdl/complex_fir_interpolator_x2_unit.sv
sim/tb.sv
